// File: hw/rtl/tlsi_pkg.sv
// ----------------------------------------------------------------------------
// Tank level shape interpolator package
// Shared widths, register indexes, constants and the flag bundle that travels
// between the segment selector and the output stage.
// ----------------------------------------------------------------------------
package tlsi_pkg;

   // default number of table entries above the origin (user points + top end)
   localparam int SHAPE_TABLE_LIMIT = 10;

   // divider bits resolved per pipeline stage
   localparam int DIV_STEP_N = 4;

   // payload and register widths
   localparam int HEIGHT_W    = 16;
   localparam int RAW_W       = 13;
   localparam int CAP_W       = 20;
   localparam int COUNT_W     = 4;
   localparam int SHAPE_W     = 63;
   localparam int PCT_W       = 7;
   localparam int LEVEL_W     = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 63;

   // Q16 fraction: 0..65536 needs 17 bits
   localparam int Q_FRAC_W = 16;
   localparam int LQ_W     = Q_FRAC_W + 1;
   // fraction times 100, at most 6553600 plus rounding
   localparam int LQ100_W  = 23;

   // second divider operands
   localparam int NUM2_W = 31;
   localparam int DEN2_W = 14;

   localparam int PCT_SCALE = 100;
   localparam logic [PCT_W-1:0]   PCT_FULL = 7'd100;
   localparam logic [LQ_W-1:0]    Q_ONE    = 17'h10000;
   localparam int                 Q_HALF   = 32768;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_DOWN      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAW_EMPTY     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAW_FULL      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHAPE_COUNT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHAPE_HEIGHTS = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHAPE_VOLUMES = 3'd6;

   // reset values that are not zero
   localparam logic [RAW_W-1:0] RAW_FULL_RST = 13'd200;
   localparam logic [CAP_W-1:0] CAPACITY_RST = 20'd200;

   // per-request flags: invalid request, forced zero, forced full
   typedef struct packed {
      logic inv;
      logic zero;
      logic sat;
   } tlsi_flags_type;

endpackage

// File: hw/rtl/tlsi_interfaces.sv
// ----------------------------------------------------------------------------
// Tank level shape interpolator channels
// Valid/ready channels for readings, results and register writes.
// ----------------------------------------------------------------------------
interface tlsi_req_if;
   logic                          valid;
   logic                          ready;
   logic [tlsi_pkg::HEIGHT_W-1:0] raw_height;
   logic                          raw_valid;

   modport source (output valid, raw_height, raw_valid, input ready);
   modport sink   (input valid, raw_height, raw_valid, output ready);
endinterface

interface tlsi_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tlsi_pkg::LEVEL_W-1:0] level_percent;
   logic [tlsi_pkg::CAP_W-1:0]   remaining;
   logic                         status;

   modport source (output valid, level_percent, remaining, status, input ready);
   modport sink   (input valid, level_percent, remaining, status, output ready);
endinterface

interface tlsi_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tlsi_pkg::CSR_INDEX_W-1:0] index;
   logic [tlsi_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/tank_level_shape_interpolator.sv
// ----------------------------------------------------------------------------
// Tank level shape interpolator
// Raw height reading to fill level, remaining volume and status, through a
// linear calibration and an optional piecewise-linear tank shape.
// ----------------------------------------------------------------------------
// Takes one reading per clock while the output is not stalled and gives one
// result per reading, in order. Two pipelined dividers, with DIV_STEP_N
// quotient bits per stage (four by default), do the work: one for the linear
// fraction, one for the shape interpolation. The whole pipe advances when
// the output register is empty or its result is being taken, so a stalled
// result holds every request behind it. Registers may be written at any
// time the block holds no request; the write port is always ready. Shape
// points are taken as given: the user checks that heights rise, not the block.
module tank_level_shape_interpolator #(
   parameter int SHAPE_TABLE_LIMIT = tlsi_pkg::SHAPE_TABLE_LIMIT,
   parameter int DIV_STEP_N        = tlsi_pkg::DIV_STEP_N
) (
   input logic       clock,
   input logic       reset,
   tlsi_req_if.sink  req_bus,
   tlsi_rsp_if.source rsp_bus,
   tlsi_csr_if.sink  csr_bus
);

   localparam int RAW_W   = tlsi_pkg::RAW_W;
   localparam int FRAC_W  = tlsi_pkg::Q_FRAC_W;
   localparam int LQ_W    = tlsi_pkg::LQ_W;
   localparam int N_W     = tlsi_pkg::HEIGHT_W + 2;
   localparam int D_W     = RAW_W + 1;
   localparam int NUM1_W  = RAW_W + FRAC_W;
   localparam int PCAP_W  = LQ_W + tlsi_pkg::CAP_W;
   localparam int L100_W  = tlsi_pkg::LQ100_W;
   localparam int FLAGS_W = $bits(tlsi_pkg::tlsi_flags_type);

   // ---- configuration registers ----
   logic                           top_down_ff;
   logic [RAW_W-1:0]               raw_empty_ff;
   logic [RAW_W-1:0]               raw_full_ff;
   logic [tlsi_pkg::CAP_W-1:0]     capacity_ff;
   logic [tlsi_pkg::COUNT_W-1:0]   shape_count_ff;
   logic [tlsi_pkg::SHAPE_W-1:0]   shape_heights_ff;
   logic [tlsi_pkg::SHAPE_W-1:0]   shape_volumes_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_down_ff      <= 1'b0;
         raw_empty_ff     <= '0;
         raw_full_ff      <= tlsi_pkg::RAW_FULL_RST;
         capacity_ff      <= tlsi_pkg::CAPACITY_RST;
         shape_count_ff   <= '0;
         shape_heights_ff <= '0;
         shape_volumes_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            tlsi_pkg::CSR_TOP_DOWN:      top_down_ff      <= csr_bus.data[0];
            tlsi_pkg::CSR_RAW_EMPTY:     raw_empty_ff     <= csr_bus.data[RAW_W-1:0];
            tlsi_pkg::CSR_RAW_FULL:      raw_full_ff      <= csr_bus.data[RAW_W-1:0];
            tlsi_pkg::CSR_CAPACITY:      capacity_ff      <= csr_bus.data[tlsi_pkg::CAP_W-1:0];
            tlsi_pkg::CSR_SHAPE_COUNT:   shape_count_ff   <= csr_bus.data[tlsi_pkg::COUNT_W-1:0];
            tlsi_pkg::CSR_SHAPE_HEIGHTS: shape_heights_ff <= csr_bus.data;
            tlsi_pkg::CSR_SHAPE_VOLUMES: shape_volumes_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // ---- pipeline flow: move when the output register frees up ----
   logic out_vld_ff;
   logic advance;

   assign advance       = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // ---- front stage: calibration check and linear dividend ----
   logic                  bad;
   logic                  inv_in;
   logic signed [N_W-1:0] n_raw, n_adj;
   logic signed [D_W-1:0] d_raw, d_adj;
   logic [RAW_W-1:0]      d_pos;
   logic [RAW_W-1:0]      nval_in;
   logic                  f0_vld_ff;
   logic                  f0_inv_ff;
   logic [RAW_W-1:0]      f0_num_ff;
   logic [RAW_W-1:0]      f0_den_ff;

   assign bad    = top_down_ff ? (raw_empty_ff <= raw_full_ff) :
                                 (raw_empty_ff >= raw_full_ff);
   assign inv_in = !req_bus.raw_valid || bad;
   assign n_raw  = $signed(N_W'(req_bus.raw_height)) - $signed(N_W'(raw_empty_ff));
   assign d_raw  = $signed({1'b0, raw_full_ff}) - $signed({1'b0, raw_empty_ff});

   // top-down mounting: flip both signs
   always_comb begin
      if (d_raw[D_W-1]) begin
         n_adj = -n_raw;
         d_adj = -d_raw;
      end else begin
         n_adj = n_raw;
         d_adj = d_raw;
      end
   end

   assign d_pos = d_adj[RAW_W-1:0];

   // clamp below empty to zero and above full to the span itself
   always_comb begin
      if (n_adj[N_W-1] || n_adj == '0) begin
         nval_in = '0;
      end else if (n_adj >= $signed(N_W'(d_pos))) begin
         nval_in = d_pos;
      end else begin
         nval_in = n_adj[RAW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_vld_ff <= 1'b0;
      end else if (advance) begin
         f0_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f0_inv_ff <= inv_in;
         f0_num_ff <= nval_in;
         f0_den_ff <= bad ? RAW_W'(1) : d_pos;
      end
   end

   // ---- linear fraction divider ----
   logic            lin_valid;
   logic [LQ_W-1:0] lin_lq;
   logic            lin_inv;

   tlsi_div_pipe #(
      .NUM_W  (NUM1_W),
      .DEN_W  (RAW_W),
      .QUO_W  (LQ_W),
      .STEP_N (DIV_STEP_N),
      .SIDE_W (1)
   ) u_lin_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f0_vld_ff),
      .in_num    ({f0_num_ff, {FRAC_W{1'b0}}}),
      .in_den    (f0_den_ff),
      .in_side   (f0_inv_ff),
      .out_valid (lin_valid),
      .out_quo   (lin_lq),
      .out_side  (lin_inv)
   );

   // ---- shape segment selection ----
   logic                          seg_valid;
   logic [tlsi_pkg::NUM2_W-1:0]   seg_num;
   logic [tlsi_pkg::DEN2_W-1:0]   seg_den;
   tlsi_pkg::tlsi_flags_type      seg_flags;

   tlsi_seg_sel #(
      .SHAPE_TABLE_LIMIT (SHAPE_TABLE_LIMIT)
   ) u_seg_sel (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (lin_valid),
      .in_inv        (lin_inv),
      .in_lq         (lin_lq),
      .shape_count   (shape_count_ff),
      .shape_heights (shape_heights_ff),
      .shape_volumes (shape_volumes_ff),
      .out_valid     (seg_valid),
      .out_num       (seg_num),
      .out_den       (seg_den),
      .out_flags     (seg_flags)
   );

   // ---- shape interpolation divider ----
   logic                     shp_valid;
   logic [LQ_W-1:0]          shp_quo;
   logic [FLAGS_W-1:0]       shp_side;
   tlsi_pkg::tlsi_flags_type shp_flags;

   tlsi_div_pipe #(
      .NUM_W  (tlsi_pkg::NUM2_W),
      .DEN_W  (tlsi_pkg::DEN2_W),
      .QUO_W  (LQ_W),
      .STEP_N (DIV_STEP_N),
      .SIDE_W (FLAGS_W)
   ) u_seg_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (seg_valid),
      .in_num    (seg_num),
      .in_den    (seg_den),
      .in_side   (seg_flags),
      .out_valid (shp_valid),
      .out_quo   (shp_quo),
      .out_side  (shp_side)
   );

   assign shp_flags = tlsi_pkg::tlsi_flags_type'(shp_side);

   // ---- scaling stage: fraction times 100 and times capacity ----
   logic [LQ_W-1:0]   lq_fin;
   logic [PCAP_W-1:0] pcap_in;
   logic [L100_W-1:0] p100_in;
   logic              f1_vld_ff;
   logic              f1_inv_ff;
   logic [PCAP_W-1:0] f1_pcap_ff;
   logic [L100_W-1:0] f1_p100_ff;

   always_comb begin
      if (shp_flags.sat) begin
         lq_fin = tlsi_pkg::Q_ONE;
      end else if (shp_flags.zero) begin
         lq_fin = '0;
      end else begin
         lq_fin = shp_quo;
      end
   end

   assign pcap_in = PCAP_W'(lq_fin) * PCAP_W'(capacity_ff);
   assign p100_in = L100_W'(lq_fin) * L100_W'(tlsi_pkg::PCT_SCALE);

   // ---- output register: round half up, blank invalid requests ----
   logic [PCAP_W-1:0]            pcap_rnd;
   logic [L100_W-1:0]            p100_rnd;
   logic [tlsi_pkg::LEVEL_W-1:0] out_level_ff;
   logic [tlsi_pkg::CAP_W-1:0]   out_remain_ff;
   logic                         out_status_ff;

   assign pcap_rnd = f1_pcap_ff + PCAP_W'(tlsi_pkg::Q_HALF);
   assign p100_rnd = f1_p100_ff + L100_W'(tlsi_pkg::Q_HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         f1_vld_ff  <= shp_valid;
         out_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_inv_ff     <= shp_flags.inv;
         f1_pcap_ff    <= pcap_in;
         f1_p100_ff    <= p100_in;
         out_status_ff <= f1_inv_ff;
         out_level_ff  <= f1_inv_ff ? '0 : p100_rnd[L100_W-1:FRAC_W];
         out_remain_ff <= f1_inv_ff ? '0 : pcap_rnd[tlsi_pkg::CAP_W+FRAC_W-1:FRAC_W];
      end
   end

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.level_percent = out_level_ff;
   assign rsp_bus.remaining     = out_remain_ff;
   assign rsp_bus.status        = out_status_ff;

`ifndef SYNTH
   // level never exceeds full scale
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.level_percent <= tlsi_pkg::LEVEL_MAX)
      else $error("level above 100 percent");

   // an invalid result carries no level and no volume
   a_invalid_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status |->
         rsp_bus.level_percent == '0 && rsp_bus.remaining == '0)
      else $error("invalid result with non-zero payload");

   // forced zero and forced full never apply together
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      seg_valid |-> !(seg_flags.zero && seg_flags.sat))
      else $error("segment flags zero and full both set");
`endif

endmodule

// File: hw/rtl/tlsi_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Resolves STEP_N quotient bits per register stage, MSB first. The dividend
// must be below den << QUO_W. Side-band bits travel with each request.
// ----------------------------------------------------------------------------
module tlsi_div_pipe #(
   parameter int NUM_W  = 29,
   parameter int DEN_W  = 13,
   parameter int QUO_W  = 17,
   parameter int STEP_N = 4,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CMP_W   = DEN_W + QUO_W;
   localparam int STAGE_N = (QUO_W + STEP_N - 1) / STEP_N;

   logic [CMP_W-1:0]  rem_src  [STAGE_N];
   logic [CMP_W-1:0]  rem_in   [STAGE_N];
   logic [CMP_W-1:0]  rem_ff   [STAGE_N];
   logic [QUO_W-1:0]  quo_src  [STAGE_N];
   logic [QUO_W-1:0]  quo_in   [STAGE_N];
   logic [QUO_W-1:0]  quo_ff   [STAGE_N];
   logic [DEN_W-1:0]  den_src  [STAGE_N];
   logic [DEN_W-1:0]  den_ff   [STAGE_N];
   logic [SIDE_W-1:0] side_src [STAGE_N];
   logic [SIDE_W-1:0] side_ff  [STAGE_N];
   logic [STAGE_N-1:0] vld_src;
   logic [STAGE_N-1:0] vld_ff;

   for (genvar s = 0; s < STAGE_N; s++) begin : g_stage
      // stage inputs: module ports for the first, previous registers after
      if (s == 0) begin : g_first
         assign rem_src[s]  = CMP_W'(in_num);
         assign quo_src[s]  = '0;
         assign den_src[s]  = in_den;
         assign side_src[s] = in_side;
         assign vld_src[s]  = in_valid;
      end else begin : g_next
         assign rem_src[s]  = rem_ff[s-1];
         assign quo_src[s]  = quo_ff[s-1];
         assign den_src[s]  = den_ff[s-1];
         assign side_src[s] = side_ff[s-1];
         assign vld_src[s]  = vld_ff[s-1];
      end

      // compare and subtract for this stage's quotient bits
      always_comb begin
         rem_in[s] = rem_src[s];
         quo_in[s] = quo_src[s];
         for (int j = 0; j < STEP_N; j++) begin
            if (s * STEP_N + j < QUO_W) begin
               if (rem_in[s] >= (CMP_W'(den_src[s]) << (QUO_W - 1 - (s * STEP_N + j)))) begin
                  rem_in[s] = rem_in[s] - (CMP_W'(den_src[s]) << (QUO_W - 1 - (s * STEP_N + j)));
                  quo_in[s] = {quo_in[s][QUO_W-2:0], 1'b1};
               end else begin
                  quo_in[s] = {quo_in[s][QUO_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_src;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= den_src;
         side_ff <= side_src;
      end
   end

   assign out_valid = vld_ff[STAGE_N-1];
   assign out_quo   = quo_ff[STAGE_N-1];
   assign out_side  = side_ff[STAGE_N-1];

endmodule

// File: hw/rtl/tlsi_seg_sel.sv
// ----------------------------------------------------------------------------
// Tank shape segment selector
// Finds the shape segment that holds the fill fraction and builds the
// interpolation dividend and divisor, with zero and full-scale overrides.
// Four register stages: scale, search, multiply, sum and range check.
// ----------------------------------------------------------------------------
module tlsi_seg_sel #(
   parameter int SHAPE_TABLE_LIMIT = tlsi_pkg::SHAPE_TABLE_LIMIT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic                            in_inv,
   input  logic [tlsi_pkg::LQ_W-1:0]       in_lq,
   input  logic [tlsi_pkg::COUNT_W-1:0]    shape_count,
   input  logic [tlsi_pkg::SHAPE_W-1:0]    shape_heights,
   input  logic [tlsi_pkg::SHAPE_W-1:0]    shape_volumes,
   output logic                            out_valid,
   output logic [tlsi_pkg::NUM2_W-1:0]     out_num,
   output logic [tlsi_pkg::DEN2_W-1:0]     out_den,
   output tlsi_pkg::tlsi_flags_type        out_flags
);

   localparam int PT_N    = SHAPE_TABLE_LIMIT - 1;
   localparam int PCT_W   = tlsi_pkg::PCT_W;
   localparam int FRAC_W  = tlsi_pkg::Q_FRAC_W;
   localparam int L100_W  = tlsi_pkg::LQ100_W;
   localparam int DIFF_W  = PCT_W + 1;
   localparam int BASE_W  = L100_W + 2;
   localparam int PA_W    = 2 * DIFF_W;
   localparam int PB_W    = BASE_W + DIFF_W;
   localparam int NUM_S_W = PB_W + 1;
   localparam int DEN_W   = tlsi_pkg::DEN2_W;
   localparam int LIM_W   = DEN_W + FRAC_W + 1;

   // ---- stage 1: fraction times 100 ----
   logic              s1_vld_ff;
   logic              s1_inv_ff;
   logic [L100_W-1:0] s1_lq100_ff;
   logic [L100_W-1:0] s1_lq100_in;

   assign s1_lq100_in = L100_W'(in_lq) * L100_W'(tlsi_pkg::PCT_SCALE);

   // ---- stage 2: table build and first segment whose top is at or above ----
   logic [tlsi_pkg::COUNT_W-1:0] cnt_eff;
   logic [PCT_W-1:0] ent_h [SHAPE_TABLE_LIMIT+1];
   logic [PCT_W-1:0] ent_v [SHAPE_TABLE_LIMIT+1];
   logic [PCT_W-1:0] h0_in, v0_in, h1_in, v1_in;
   logic              s2_vld_ff;
   logic              s2_inv_ff;
   logic [L100_W-1:0] s2_lq100_ff;
   logic [PCT_W-1:0]  s2_h0_ff, s2_v0_ff, s2_h1_ff, s2_v1_ff;

   assign cnt_eff = (shape_count > tlsi_pkg::COUNT_W'(PT_N)) ?
                    tlsi_pkg::COUNT_W'(PT_N) : shape_count;

   always_comb begin
      ent_h[0] = '0;
      ent_v[0] = '0;
      for (int e = 1; e <= PT_N; e++) begin
         if (tlsi_pkg::COUNT_W'(e) <= cnt_eff) begin
            ent_h[e] = shape_heights[PCT_W*(e-1) +: PCT_W];
            ent_v[e] = shape_volumes[PCT_W*(e-1) +: PCT_W];
         end else begin
            ent_h[e] = tlsi_pkg::PCT_FULL;
            ent_v[e] = tlsi_pkg::PCT_FULL;
         end
      end
      ent_h[SHAPE_TABLE_LIMIT] = tlsi_pkg::PCT_FULL;
      ent_v[SHAPE_TABLE_LIMIT] = tlsi_pkg::PCT_FULL;
   end

   // lowest hit wins: scan from the top down
   always_comb begin
      h1_in = ent_h[SHAPE_TABLE_LIMIT];
      v1_in = ent_v[SHAPE_TABLE_LIMIT];
      h0_in = ent_h[SHAPE_TABLE_LIMIT-1];
      v0_in = ent_v[SHAPE_TABLE_LIMIT-1];
      for (int e = SHAPE_TABLE_LIMIT; e >= 1; e--) begin
         if ({ent_h[e], {FRAC_W{1'b0}}} >= s1_lq100_ff) begin
            h1_in = ent_h[e];
            v1_in = ent_v[e];
            h0_in = ent_h[e-1];
            v0_in = ent_v[e-1];
         end
      end
   end

   // ---- stage 3: the two products of the interpolation dividend ----
   logic signed [DIFF_W-1:0] dh;
   logic signed [DIFF_W-1:0] dv;
   logic signed [DIFF_W-1:0] v0_s;
   logic signed [BASE_W-1:0] base;
   logic signed [PA_W-1:0]   pa_in;
   logic signed [PB_W-1:0]   pb_in;
   logic                     s3_vld_ff;
   logic                     s3_inv_ff;
   logic signed [PA_W-1:0]   s3_pa_ff;
   logic signed [PB_W-1:0]   s3_pb_ff;
   logic                     s3_mono_ff;
   logic [PCT_W-1:0]         s3_dh_ff;
   logic [PCT_W-1:0]         s3_v1_ff;

   assign dh    = $signed({1'b0, s2_h1_ff}) - $signed({1'b0, s2_h0_ff});
   assign dv    = $signed({1'b0, s2_v1_ff}) - $signed({1'b0, s2_v0_ff});
   assign v0_s  = $signed({1'b0, s2_v0_ff});
   assign base  = $signed({2'b00, s2_lq100_ff}) -
                  $signed({2'b00, s2_h0_ff, {FRAC_W{1'b0}}});
   assign pa_in = PA_W'(v0_s) * PA_W'(dh);
   assign pb_in = PB_W'(base) * PB_W'(dv);

   // ---- stage 4: dividend, divisor and range overrides ----
   logic signed [NUM_S_W-1:0] num_s;
   logic signed [NUM_S_W-1:0] cand_num;
   logic [DEN_W-1:0]          cand_den;
   logic [LIM_W-1:0]          lim;
   logic                      neg;
   logic                      sat;
   logic                      s4_vld_ff;
   logic [tlsi_pkg::NUM2_W-1:0] s4_num_ff;
   logic [DEN_W-1:0]          s4_den_ff;
   tlsi_pkg::tlsi_flags_type  s4_flags_ff;
   tlsi_pkg::tlsi_flags_type  flags_in;

   assign num_s = (NUM_S_W'(s3_pa_ff) <<< FRAC_W) + NUM_S_W'(s3_pb_ff);

   // rising segment: interpolate over dh * 100; flat or falling: plain V1 scaled by 1/100
   always_comb begin
      if (s3_mono_ff) begin
         cand_num = num_s;
         cand_den = DEN_W'(s3_dh_ff) * DEN_W'(tlsi_pkg::PCT_SCALE);
      end else begin
         cand_num = $signed(NUM_S_W'({s3_v1_ff, {FRAC_W{1'b0}}}));
         cand_den = DEN_W'(tlsi_pkg::PCT_SCALE);
      end
   end

   // quotient above one exactly when dividend reaches 65537 * divisor
   assign lim = LIM_W'({cand_den, {FRAC_W{1'b0}}}) + LIM_W'(cand_den);
   assign neg = cand_num[NUM_S_W-1];
   assign sat = !neg && ($unsigned(cand_num) >= NUM_S_W'(lim));

   always_comb begin
      flags_in.inv  = s3_inv_ff;
      flags_in.zero = neg;
      flags_in.sat  = sat;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_inv_ff   <= in_inv;
         s1_lq100_ff <= s1_lq100_in;

         s2_inv_ff   <= s1_inv_ff;
         s2_lq100_ff <= s1_lq100_ff;
         s2_h0_ff    <= h0_in;
         s2_v0_ff    <= v0_in;
         s2_h1_ff    <= h1_in;
         s2_v1_ff    <= v1_in;

         s3_inv_ff   <= s2_inv_ff;
         s3_pa_ff    <= pa_in;
         s3_pb_ff    <= pb_in;
         s3_mono_ff  <= (s2_h1_ff > s2_h0_ff);
         s3_dh_ff    <= dh[PCT_W-1:0];
         s3_v1_ff    <= s2_v1_ff;

         s4_num_ff   <= (neg || sat) ? '0 : cand_num[tlsi_pkg::NUM2_W-1:0];
         s4_den_ff   <= cand_den;
         s4_flags_ff <= flags_in;
      end
   end

   assign out_valid = s4_vld_ff;
   assign out_num   = s4_num_ff;
   assign out_den   = s4_den_ff;
   assign out_flags = s4_flags_ff;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Tank level shape interpolator testbench
// Sends readings through many calibrations and tank shapes. A model in the
// bench works out the expected level, remaining volume and status for each
// request, and the result stream is checked against it in order. Both sides
// idle and stall at random, and the output is held off once long enough to
// back the pipe up into its input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LQ_W              = tlsi_pkg::LQ_W;
   localparam int DIV_STEP_N        = tlsi_pkg::DIV_STEP_N;
   localparam int SHAPE_TABLE_LIMIT = tlsi_pkg::SHAPE_TABLE_LIMIT;
   localparam int SHAPE_W           = tlsi_pkg::SHAPE_W;
   localparam int PCT_SCALE         = tlsi_pkg::PCT_SCALE;
   localparam int LEVEL_W           = tlsi_pkg::LEVEL_W;
   localparam int CAP_W             = tlsi_pkg::CAP_W;
   localparam int RAW_W             = tlsi_pkg::RAW_W;
   localparam int COUNT_W           = tlsi_pkg::COUNT_W;
   localparam int HEIGHT_W          = tlsi_pkg::HEIGHT_W;
   localparam int Q_HALF            = tlsi_pkg::Q_HALF;
   localparam int Q_FRAC_W          = tlsi_pkg::Q_FRAC_W;
   localparam int CSR_INDEX_W       = tlsi_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W        = tlsi_pkg::CSR_DATA_W;

   localparam int PIPE_LATENCY    = 3 + 2 * ((LQ_W + DIV_STEP_N - 1) / DIV_STEP_N) + 4;
   localparam int SETTLE_CYCLES   = PIPE_LATENCY + 8;
   localparam int STALL_LIMIT     = 4000;
   localparam int IDLE_PCT        = 20;
   localparam int MAX_REPORTS     = 10;
   localparam int RSP_HOLD_CYCLES = 150;
   localparam int POINT_W         = 7;
   localparam int MAX_POINTS      = SHAPE_W / POINT_W;
   localparam int PCT_TOP         = PCT_SCALE - 1;
   localparam int RAW_CFG_MAX     = 5000;
   localparam int CAP_CFG_MAX     = 1000000;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_ITEMS     = 100;
   localparam longint Q_UNITY     = longint'(tlsi_pkg::Q_ONE);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_pct;
      logic [CAP_W-1:0]   remaining;
      logic               status;
   } gauge_type;

   typedef int unsigned pct_list_type [MAX_POINTS];

   logic clock = 1'b0;
   logic reset;

   tlsi_req_if req_if ();
   tlsi_rsp_if rsp_if ();
   tlsi_csr_if csr_if ();

   tank_level_shape_interpolator u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // bench copy of the calibration registers
   logic               cfg_top_down    = 1'b0;
   logic [RAW_W-1:0]   cfg_raw_empty   = '0;
   logic [RAW_W-1:0]   cfg_raw_full    = tlsi_pkg::RAW_FULL_RST;
   logic [CAP_W-1:0]   cfg_capacity    = tlsi_pkg::CAPACITY_RST;
   logic [COUNT_W-1:0] cfg_shape_count = '0;
   logic [SHAPE_W-1:0] cfg_heights     = '0;
   logic [SHAPE_W-1:0] cfg_volumes     = '0;

   gauge_type gauge_pending [$];
   int        fault_count  = 0;
   int        quiet_cycles = 0;
   int        stall_ticket = 0;
   bit        steady       = 1'b0;

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Level model
   // ------------------------------------------------------------------------
   function automatic longint clamp_q(input longint x);
      if (x < 0) return 0;
      if (x > Q_UNITY) return Q_UNITY;
      return x;
   endfunction

   // entry 0 is the origin, entries past the user points are the full corner
   function automatic void shape_point(input int unsigned ent, input int unsigned cnt,
                                       output longint h, output longint v);
      if (ent == 0) begin
         h = 0;
         v = 0;
      end else if (ent > cnt) begin
         h = PCT_SCALE;
         v = PCT_SCALE;
      end else begin
         h = longint'(cfg_heights[POINT_W*(ent-1) +: POINT_W]);
         v = longint'(cfg_volumes[POINT_W*(ent-1) +: POINT_W]);
      end
   endfunction

   function automatic longint shape_remap(input longint lq);
      int unsigned cnt;
      int unsigned ent;
      longint      h0, v0, h1, v1, num, den, res;
      bit          found;
      cnt = int'(cfg_shape_count);
      if (cnt > SHAPE_TABLE_LIMIT - 1) cnt = SHAPE_TABLE_LIMIT - 1;
      res = lq;
      found = 1'b0;
      if (cnt != 0) begin
         for (ent = 1; ent <= cnt + 1 && !found; ent++) begin
            shape_point(ent, cnt, h1, v1);
            if (h1 * Q_UNITY >= lq * PCT_SCALE) begin
               found = 1'b1;
               shape_point(ent - 1, cnt, h0, v0);
               if (h1 <= h0) begin
                  // flat or falling segment: take the upper volume as it is
                  res = clamp_q((v1 * Q_UNITY) / PCT_SCALE);
               end else begin
                  den = PCT_SCALE * (h1 - h0);
                  num = v0 * Q_UNITY * (h1 - h0) + (lq * PCT_SCALE - h0 * Q_UNITY) * (v1 - v0);
                  res = (num < 0) ? 0 : clamp_q(num / den);
               end
            end
         end
      end
      return res;
   endfunction

   function automatic gauge_type predict_gauge(input logic [HEIGHT_W-1:0] height,
                                               input logic ok);
      longint    e, f, n, d, lq;
      bit        bad;
      gauge_type r;
      e = longint'(cfg_raw_empty);
      f = longint'(cfg_raw_full);
      bad = cfg_top_down ? (e <= f) : (e >= f);
      r = '0;
      if (!ok || bad) begin
         r.status = 1'b1;
      end else begin
         n = longint'(height) - e;
         d = f - e;
         if (d < 0) begin
            n = -n;
            d = -d;
         end
         if (n <= 0) lq = 0;
         else if (n >= d) lq = Q_UNITY;
         else lq = (n * Q_UNITY) / d;
         lq = shape_remap(lq);
         r.level_pct = LEVEL_W'((lq * PCT_SCALE + Q_HALF) >>> Q_FRAC_W);
         r.remaining = CAP_W'((lq * longint'(cfg_capacity) + Q_HALF) >>> Q_FRAC_W);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------
   task automatic send_reading(input int height, input bit ok);
      gauge_type want;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      want = predict_gauge(HEIGHT_W'(height), ok);
      req_if.valid      <= 1'b1;
      req_if.raw_height <= HEIGHT_W'(height);
      req_if.raw_valid  <= ok;
      do @(posedge clock); while (!req_if.ready);
      gauge_pending.push_back(want);
   endtask

   // stop sending and let every request leave the pipe
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (gauge_pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         tlsi_pkg::CSR_TOP_DOWN:      cfg_top_down    = value[0];
         tlsi_pkg::CSR_RAW_EMPTY:     cfg_raw_empty   = value[RAW_W-1:0];
         tlsi_pkg::CSR_RAW_FULL:      cfg_raw_full    = value[RAW_W-1:0];
         tlsi_pkg::CSR_CAPACITY:      cfg_capacity    = value[CAP_W-1:0];
         tlsi_pkg::CSR_SHAPE_COUNT:   cfg_shape_count = value[COUNT_W-1:0];
         tlsi_pkg::CSR_SHAPE_HEIGHTS: cfg_heights     = value[SHAPE_W-1:0];
         tlsi_pkg::CSR_SHAPE_VOLUMES: cfg_volumes     = value[SHAPE_W-1:0];
         default: ;
      endcase
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_tank(input bit td, input int empty, input int full,
                               input int cap, input int cnt,
                               input logic [SHAPE_W-1:0] hts,
                               input logic [SHAPE_W-1:0] vols);
      wait_idle();
      write_reg(tlsi_pkg::CSR_TOP_DOWN,      CSR_DATA_W'(td));
      write_reg(tlsi_pkg::CSR_RAW_EMPTY,     CSR_DATA_W'(empty));
      write_reg(tlsi_pkg::CSR_RAW_FULL,      CSR_DATA_W'(full));
      write_reg(tlsi_pkg::CSR_CAPACITY,      CSR_DATA_W'(cap));
      write_reg(tlsi_pkg::CSR_SHAPE_COUNT,   CSR_DATA_W'(cnt));
      write_reg(tlsi_pkg::CSR_SHAPE_HEIGHTS, CSR_DATA_W'(hts));
      write_reg(tlsi_pkg::CSR_SHAPE_VOLUMES, CSR_DATA_W'(vols));
   endtask

   function automatic logic [SHAPE_W-1:0] pack_points(input pct_list_type p);
      logic [SHAPE_W-1:0] packed_pts;
      packed_pts = '0;
      for (int i = 0; i < MAX_POINTS; i++)
         packed_pts[POINT_W*i +: POINT_W] = POINT_W'(p[i]);
      return packed_pts;
   endfunction

   // min(k, MAX_POINTS) strictly rising percentages in 1..99; unused slots hold noise
   function automatic logic [SHAPE_W-1:0] rising_points(input int unsigned k);
      logic [SHAPE_W-1:0] packed_pts;
      int unsigned        prev, top, i, used;
      packed_pts = '0;
      prev = 0;
      used = (k > MAX_POINTS) ? MAX_POINTS : k;
      for (i = 0; i < MAX_POINTS; i++) begin
         if (i < used) begin
            top  = PCT_TOP - (used - 1 - i);
            prev = $urandom_range(prev + 1, prev + 1 + (top - prev - 1) / (used - i));
            packed_pts[POINT_W*i +: POINT_W] = POINT_W'(prev);
         end else begin
            packed_pts[POINT_W*i +: POINT_W] = POINT_W'($urandom_range(127));
         end
      end
      return packed_pts;
   endfunction

   // mostly inside the calibrated span, some near its ends, some anywhere
   function automatic int pick_height();
      int lo, hi, sel, h;
      lo  = (cfg_raw_empty < cfg_raw_full) ? int'(cfg_raw_empty) : int'(cfg_raw_full);
      hi  = (cfg_raw_empty < cfg_raw_full) ? int'(cfg_raw_full) : int'(cfg_raw_empty);
      sel = $urandom_range(99);
      if (sel < 70) begin
         h = $urandom_range(hi, lo);
      end else if (sel < 80) begin
         h = ((sel < 75) ? lo : hi) + int'($urandom_range(4)) - 2;
         if (h < 0) h = 0;
      end else begin
         h = $urandom_range(16'hFFFF);
      end
      return h;
   endfunction

   // ------------------------------------------------------------------------
   // Result sink: random stalls, or a long hold when a new ticket is issued
   // ------------------------------------------------------------------------
   initial begin : rsp_sink
      int hold_left;
      int ticket_taken;
      hold_left    = 0;
      ticket_taken = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_ticket != ticket_taken) begin
            ticket_taken = stall_ticket;
            hold_left    = RSP_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result check against the oldest expected result
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      gauge_type want, got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.level_pct = rsp_if.level_percent;
         got.remaining = rsp_if.remaining;
         got.status    = rsp_if.status;
         if (gauge_pending.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("%0t: unexpected result level %0d remaining %0d status %0d",
                        $realtime, got.level_pct, got.remaining, got.status);
         end else begin
            want = gauge_pending.pop_front();
            if (got !== want) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display({"%0t: mismatch: expected level %0d remaining %0d status %0d,",
                            " got level %0d remaining %0d status %0d"},
                           $realtime, want.level_pct, want.remaining, want.status,
                           got.level_pct, got.remaining, got.status);
            end
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // register values straight out of reset
   task automatic check_reset_calibration();
      send_reading(0, 1'b1);
      send_reading(100, 1'b1);
      send_reading(200, 1'b1);
      send_reading(16'hFFFF, 1'b1);
      send_reading(150, 1'b0);
   endtask

   // 1/8 full gives 12.5 % and, with capacity 4, half a unit: both round up
   task automatic check_rounding_ties();
      program_tank(1'b0, 0, 8, 4, 0, '0, '0);
      send_reading(1, 1'b1);
      send_reading(3, 1'b1);
      send_reading(8, 1'b1);
   endtask

   // empty/full equal or in the wrong order for the mounting, then a sound top-down set
   task automatic check_calibration_order();
      program_tank(1'b0, 100, 100, 200, 0, '0, '0);
      send_reading(100, 1'b1);
      program_tank(1'b0, 300, 100, 200, 0, '0, '0);
      send_reading(200, 1'b1);
      program_tank(1'b1, 100, 300, 200, 0, '0, '0);
      send_reading(200, 1'b1);
      program_tank(1'b1, 300, 300, 200, 0, '0, '0);
      send_reading(300, 1'b1);
      program_tank(1'b1, RAW_CFG_MAX, 0, CAP_CFG_MAX, 0, '0, '0);
      send_reading(0, 1'b1);
      send_reading(2500, 1'b1);
      send_reading(RAW_CFG_MAX, 1'b1);
      send_reading(16'hFFFF, 1'b1);
      send_reading(2500, 1'b0);
   endtask

   task automatic check_shape_table();
      // ordinary three-point shape, including a reading on a point
      program_tank(1'b0, 0, 1000, CAP_CFG_MAX, 3,
                   pack_points('{20, 50, 80, 0, 0, 0, 0, 0, 0}),
                   pack_points('{10, 40, 90, 0, 0, 0, 0, 0, 0}));
      send_reading(200, 1'b1);
      send_reading(650, 1'b1);
      send_reading(1000, 1'b1);
      // count beyond the table size falls back to nine points
      program_tank(1'b0, 0, 1000, 999, 15,
                   pack_points('{10, 20, 30, 40, 50, 60, 70, 80, 90}),
                   pack_points('{3, 8, 20, 33, 47, 60, 71, 88, 97}));
      send_reading(950, 1'b1);
      send_reading(55, 1'b1);
      // flat first segment and percentages above 100
      program_tank(1'b0, 0, 1000, 500, 2,
                   pack_points('{0, 127, 0, 0, 0, 0, 0, 0, 0}),
                   pack_points('{127, 120, 0, 0, 0, 0, 0, 0, 0}));
      send_reading(0, 1'b1);
      send_reading(500, 1'b1);
      // a write to an unused index changes nothing
      wait_idle();
      write_reg(CSR_UNUSED, '1);
      send_reading(500, 1'b1);
   endtask

   // random calibrations and shapes, each with a burst of random readings
   task automatic check_random_tanks();
      bit                 td;
      int                 a, b, lo, hi, empty, full, cap, cnt, sel;
      logic [SHAPE_W-1:0] hts, vols;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         td = 1'($urandom_range(1));
         a  = $urandom_range(RAW_CFG_MAX);
         b  = $urandom_range(RAW_CFG_MAX);
         if (a == b) b = (a == 0) ? 1 : a - 1;
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         if (phase == 0) begin
            lo = 0;
            hi = RAW_CFG_MAX;
         end
         empty = td ? hi : lo;
         full  = td ? lo : hi;
         sel   = $urandom_range(99);
         if (sel < 8) begin
            // wrong order for the mounting
            empty = td ? lo : hi;
            full  = td ? hi : lo;
         end else if (sel < 12) begin
            empty = $urandom_range((1 << RAW_W) - 1);
            full  = $urandom_range((1 << RAW_W) - 1);
         end
         if (phase == 0) cap = CAP_CFG_MAX;
         else if (phase == 1) cap = 0;
         else if ($urandom_range(9) == 0) cap = $urandom_range((1 << CAP_W) - 1);
         else cap = $urandom_range(CAP_CFG_MAX);
         sel = $urandom_range(99);
         if (sel < 25) cnt = 0;
         else if (sel < 85) cnt = $urandom_range(MAX_POINTS, 1);
         else cnt = $urandom_range((1 << COUNT_W) - 1, MAX_POINTS + 1);
         if ($urandom_range(4) == 0) begin
            hts  = SHAPE_W'({$urandom(), $urandom()});
            vols = SHAPE_W'({$urandom(), $urandom()});
         end else begin
            hts  = rising_points(cnt);
            vols = rising_points(cnt);
         end
         program_tank(td, empty, full, cap, cnt, hts, vols);
         steady = (phase == RANDOM_PHASES / 2);
         repeat (PHASE_ITEMS) send_reading(pick_height(), $urandom_range(99) >= 8);
         steady = 1'b0;
      end
   endtask

   // output held off while readings keep coming: the pipe fills and stalls
   task automatic check_output_stall();
      program_tank(1'b0, 100, 4000, 7777, 4, rising_points(4), rising_points(4));
      steady = 1'b1;
      stall_ticket++;
      repeat (80) send_reading(pick_height(), 1'b1);
      steady = 1'b0;
      wait_idle();
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.raw_height = '0;
      req_if.raw_valid  = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = '0;
      csr_if.data       = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_reset_calibration();
      check_rounding_ties();
      check_calibration_order();
      check_shape_table();
      check_random_tanks();
      check_output_stall();
      wait_idle();

      if (fault_count == 0 && gauge_pending.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// File: tank_level_shape_interpolator.f
hw/rtl/tlsi_pkg.sv
hw/rtl/tlsi_interfaces.sv
hw/rtl/tlsi_div_pipe.sv
hw/rtl/tlsi_seg_sel.sv
hw/rtl/tank_level_shape_interpolator.sv
bench/tb.sv
